// File: rtl/sfb_pkg.sv
package sfb_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_REGS_DEF  = 15;

	// configuration register space is fixed at eight slots
	localparam int SLOT_W    = 3;
	localparam int SCAN_W    = 4;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	localparam logic [7:0]  HDR0      = 8'hA5;
	localparam logic [7:0]  HDR1      = 8'h5A;
	localparam int          LEN_LIMIT = 255;
	localparam int          HDR_LEN   = 6;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE = 2'd0,
		CFG_IDS    = 2'd1,
		CFG_COUNTS = 2'd2
	} cfg_idx_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	typedef struct packed {
		logic [7:0]  enable;
		logic [63:0] ids;
		logic [31:0] counts;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       error;
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN,
		ST_ERR,
		ST_HDR0,
		ST_HDR1,
		ST_LENB,
		ST_MASK,
		ST_ADV,
		ST_ID,
		ST_CNT,
		ST_VLO,
		ST_CRCLO,
		ST_CRCHI
	} state_t;

	function automatic logic slot_on(cfg_t cfg, logic [SLOT_W-1:0] s);
		return cfg.enable[s];
	endfunction

	function automatic logic [7:0] slot_id(cfg_t cfg, logic [SLOT_W-1:0] s);
		return cfg.ids[8*s +: 8];
	endfunction

	function automatic logic [CNT_W-1:0] slot_cnt_raw(cfg_t cfg, logic [SLOT_W-1:0] s);
		return cfg.counts[4*s +: 4];
	endfunction

endpackage

// File: rtl/sfb_crc16.sv
module sfb_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import sfb_pkg::*;

	// one byte through the reflected polynomial, bit by bit
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

// File: rtl/sfb_seq.sv
module sfb_seq #(
	parameter int NUM_SLOTS         = sfb_pkg::NUM_SLOTS_DEF,
	parameter int MAX_REGS_PER_SLOT = sfb_pkg::MAX_REGS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sfb_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [3:0]    input_mask,
	input  logic [15:0]   reg_value,
	input  logic          read_ok,
	input  logic          out_free,
	output sfb_pkg::emit_t emit
);
	import sfb_pkg::*;

	localparam int LenMax  = HDR_LEN + NUM_SLOTS * (2 + 2 * MAX_REGS_PER_SLOT);
	localparam int LenBits = $clog2(LenMax + 1);
	localparam int LenW    = (LenBits > 9) ? LenBits : 9;

	state_t              state_q, state_d;
	logic [SCAN_W-1:0]   scan_q, scan_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [CNT_W-1:0]    vidx_q, vidx_d;
	logic                open_q, open_d;
	logic [LenW-1:0]     len_q, len_d;
	logic [3:0]          mask_q, mask_d;
	logic [7:0]          vlo_q, vlo_d;
	logic [15:0]         crc_q, crc_d, crc_next;
	logic                crc_upd;

	logic [SLOT_W-1:0]   scan_slot;
	logic [CNT_W-1:0]    scan_cnt, slot_cnt, vidx_inc;
	logic                scan_done;

	function automatic logic [CNT_W-1:0] sat(logic [CNT_W-1:0] c);
		return (c > CNT_W'(MAX_REGS_PER_SLOT)) ? CNT_W'(MAX_REGS_PER_SLOT) : c;
	endfunction

	assign scan_slot = scan_q[SLOT_W-1:0];
	assign scan_cnt  = sat(slot_cnt_raw(cfg, scan_slot));
	assign slot_cnt  = sat(slot_cnt_raw(cfg, slot_q));
	assign scan_done = (scan_q >= SCAN_W'(NUM_SLOTS));
	assign vidx_inc  = vidx_q + CNT_W'(1);

	sfb_crc16 u_crc (
		.crc_in (crc_q),
		.data   (emit.data),
		.crc_out(crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			slot_q  <= '0;
			vidx_q  <= '0;
			open_q  <= 1'b0;
			crc_q   <= CRC_INIT;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			slot_q  <= slot_d;
			vidx_q  <= vidx_d;
			open_q  <= open_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q  <= len_d;
		mask_q <= mask_d;
		vlo_q  <= vlo_d;
	end

	always_comb begin
		state_d  = state_q;
		scan_d   = scan_q;
		slot_d   = slot_q;
		vidx_d   = vidx_q;
		open_d   = open_q;
		len_d    = len_q;
		mask_d   = mask_q;
		vlo_d    = vlo_q;
		emit     = '0;
		crc_upd  = 1'b0;
		in_ready = (state_q == ST_IDLE) && out_free;

		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (op == OP_START) begin
						scan_d  = '0;
						slot_d  = '0;
						vidx_d  = '0;
						open_d  = 1'b0;
						len_d   = LenW'(HDR_LEN);
						mask_d  = input_mask;
						state_d = ST_LEN;
					end else if (open_q) begin
						// high byte goes out with the request
						emit.valid = 1'b1;
						emit.data  = read_ok ? reg_value[15:8] : 8'h00;
						crc_upd    = 1'b1;
						vlo_d      = read_ok ? reg_value[7:0] : 8'h00;
						state_d    = ST_VLO;
					end
				end
			end
			ST_LEN: begin
				if (scan_done) begin
					state_d = (len_q > LenW'(LEN_LIMIT)) ? ST_ERR : ST_HDR0;
				end else begin
					if (slot_on(cfg, scan_slot)) begin
						len_d = len_q + LenW'(2) + LenW'({scan_cnt, 1'b0});
					end
					scan_d = scan_q + SCAN_W'(1);
				end
			end
			ST_ERR: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.last  = 1'b1;
					emit.error = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_HDR0: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = HDR0;
					crc_upd    = 1'b1;
					state_d    = ST_HDR1;
				end
			end
			ST_HDR1: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = HDR1;
					crc_upd    = 1'b1;
					state_d    = ST_LENB;
				end
			end
			ST_LENB: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = len_q[7:0];
					crc_upd    = 1'b1;
					state_d    = ST_MASK;
				end
			end
			ST_MASK: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = {4'h0, mask_q};
					crc_upd    = 1'b1;
					open_d     = 1'b1;
					scan_d     = '0;
					state_d    = ST_ADV;
				end
			end
			ST_ADV: begin
				if (scan_done) begin
					state_d = ST_CRCLO;
				end else if (!slot_on(cfg, scan_slot)) begin
					scan_d = scan_q + SCAN_W'(1);
				end else begin
					state_d = ST_ID;
				end
			end
			ST_ID: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = slot_id(cfg, scan_slot);
					crc_upd    = 1'b1;
					state_d    = ST_CNT;
				end
			end
			ST_CNT: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = {4'h0, scan_cnt};
					crc_upd    = 1'b1;
					if (scan_cnt != '0) begin
						slot_d  = scan_slot;
						vidx_d  = '0;
						state_d = ST_IDLE;
					end else begin
						scan_d  = scan_q + SCAN_W'(1);
						state_d = ST_ADV;
					end
				end
			end
			ST_VLO: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = vlo_q;
					crc_upd    = 1'b1;
					vidx_d     = vidx_inc;
					if (vidx_inc == '0 || vidx_inc >= slot_cnt) begin
						scan_d  = SCAN_W'(slot_q) + SCAN_W'(1);
						state_d = ST_ADV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CRCLO: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = crc_q[7:0];
					state_d    = ST_CRCHI;
				end
			end
			ST_CRCHI: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = crc_q[15:8];
					emit.last  = 1'b1;
					open_d     = 1'b0;
					slot_d     = '0;
					vidx_d     = '0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// restart the CRC on a start request, otherwise fold in each issued byte
	always_comb begin
		if (state_q == ST_IDLE && in_valid && in_ready && op == OP_START) begin
			crc_d = CRC_INIT;
		end else if (crc_upd) begin
			crc_d = crc_next;
		end else begin
			crc_d = crc_q;
		end
	end

endmodule

// File: rtl/sensor_frame_builder_crc16.sv
// Telemetry frame builder with Modbus CRC-16 trailer.
// Input stream (s_*): tuser[0] selects the request kind, start frame or one
// register value. A start request carries the 4-bit digital input mask, a
// value request carries a 16-bit register value and its read status.
// Output stream (m_*): frame bytes in transmit order; tlast marks the
// second CRC byte and the error result, tuser marks the single error result
// that is given when the frame length would exceed 255 bytes.
// Configuration (cfg_*): enable mask, slave ids and register counts, written
// while the block is idle; a write takes effect at the next edge.
// Sequence: a start request is taken, the sequencer sums the enabled slots
// to check the frame length, then issues the four header bytes. Each slot
// walked is then examined, and an enabled slot issues its id and count
// bytes; the end of the slots is found before the two CRC bytes. A value
// request issues two bytes, high byte first, plus that slot walk and trailer
// when a slot completes. The rate is set by the single byte sequencer, which
// issues at most one byte a cycle, while the output register is free, through
// the shared CRC byte unit. Bytes appear on m_* in the cycle after issue.
// Reset clears the configuration and closes any open frame.
// A stalled receiver holds the output register; the sequencer then waits
// and s_tready stays low until the output register can take a byte.
module sensor_frame_builder_crc16 #(
	parameter int NUM_SLOTS         = sfb_pkg::NUM_SLOTS_DEF,
	parameter int MAX_REGS_PER_SLOT = sfb_pkg::MAX_REGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // input_mask[3:0], reg_value[19:4], read_ok[20]
	input  logic [0:0]                      s_tuser,   // op[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // out_byte[7:0]
	output logic                            m_tlast,
	output logic [0:0]                      m_tuser,   // error[0]
	input  logic                            cfg_we,
	input  logic [sfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfb_pkg::CFG_W-1:0]       cfg_wdata
);
	import sfb_pkg::*;

	cfg_t  cfg_q;
	emit_t emit;
	logic  out_free;
	logic  m_tvalid_q;
	logic  [7:0] m_tdata_q;
	logic  m_tlast_q;
	logic  m_tuser_q;

	// configuration registers; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: cfg_q.enable <= cfg_wdata[7:0];
				CFG_IDS:    cfg_q.ids    <= cfg_wdata;
				CFG_COUNTS: cfg_q.counts <= cfg_wdata[31:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// output register is free when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	sfb_seq #(
		.NUM_SLOTS        (NUM_SLOTS),
		.MAX_REGS_PER_SLOT(MAX_REGS_PER_SLOT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tuser[0]),
		.input_mask(s_tdata[3:0]),
		.reg_value (s_tdata[19:4]),
		.read_ok   (s_tdata[20]),
		.out_free  (out_free),
		.emit      (emit)
	);

	// hold the byte until taken, load the next one as it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_tdata_q <= emit.data;
			m_tlast_q <= emit.last;
			m_tuser_q <= emit.error;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_tuser_q;

	// an error result is always a lone zero byte that ends its run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
		else $error("error result without last or with data");

	// ready drops after a start request, since the sequencer enters the length scan
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == OP_START |=> !s_tready)
		else $error("ready right after a start request");

	// no request is taken while the output register is blocked
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("ready while the output register is stalled");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import sfb_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int LIMIT      = 1_000_000;   // cycles before the run is declared hung
	localparam int DRAIN      = 40;          // covers the length scan plus a few bytes
	localparam int ITEM_GOAL  = 470;         // requests that produce frame bytes
	localparam int QUIET_FROM = 420;         // no idling on either side past this point
	localparam int PRINT_CAP  = 50;

	// Index 3 is not mapped to any register; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       err;
	} tx_byte_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_REQ} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_HEADER, CHK_ERROR} row_chk_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [63:0]            wval;
		logic                   op;
		logic [3:0]             mask;
		logic [15:0]            val;
		logic                   ok;
		row_chk_t               chk;
		logic [7:0]             len;
	} plan_row_t;

	// DUT connections; every input is known from time zero.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;
	logic [0:0]           m_tuser;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Frame predictor: shadow configuration and sequencing state.
	logic [7:0]  cfg_en     = '0;
	logic [63:0] cfg_ids    = '0;
	logic [31:0] cfg_cnt    = '0;
	logic        frame_live = 1'b0;
	logic [2:0]  cur_slot   = '0;
	logic [3:0]  cur_reg    = '0;
	logic [15:0] crc_run    = CRC_INIT;
	tx_byte_t    bytes_due[$];

	// Hand-typed bytes that replace the first predicted bytes of one request.
	tx_byte_t    typed_due[4];
	int          n_typed       = 0;

	plan_row_t   plan[$];
	bit          bursts_on     = 1'b0;
	int          mismatches    = 0;
	int          bytes_checked = 0;
	int          requests_used = 0;
	int          frame_starts  = 0;
	int          frame_rejects = 0;
	int          cycles        = 0;
	int          stall_left    = 0;

	sensor_frame_builder_crc16 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// Register count of a slot, clipped to the per-slot maximum.
	function automatic logic [3:0] regs_of(int s);
		logic [3:0] c;
		c = cfg_cnt[4*s +: 4];
		if (c > MAX_REGS_DEF)
			c = 4'(MAX_REGS_DEF);
		return c;
	endfunction

	function automatic void emit_raw(logic [7:0] b, logic last, logic err);
		bytes_due.push_back('{data: b, last: last, err: err});
	endfunction

	// Fold one byte into the running Modbus CRC, then queue it.
	function automatic void emit_crc_byte(logic [7:0] b);
		crc_run ^= {8'h00, b};
		for (int k = 0; k < 8; k++)
			crc_run = crc_run[0] ? ((crc_run >> 1) ^ CRC_POLY) : (crc_run >> 1);
		emit_raw(b, 1'b0, 1'b0);
	endfunction

	// Queue headers from slot 'from' on; park on the next slot that takes
	// values, or close the frame with the CRC trailer, low byte first.
	function automatic void next_slots(int from);
		for (int s = from; s < NUM_SLOTS_DEF; s++) begin
			if (!cfg_en[s])
				continue;
			emit_crc_byte(cfg_ids[8*s +: 8]);
			emit_crc_byte({4'h0, regs_of(s)});
			if (regs_of(s) != 4'd0) begin
				cur_slot = 3'(s);
				cur_reg  = 4'd0;
				return;
			end
		end
		emit_raw(crc_run[7:0], 1'b0, 1'b0);
		emit_raw(crc_run[15:8], 1'b1, 1'b0);
		frame_live = 1'b0;
		cur_slot   = '0;
		cur_reg    = '0;
	endfunction

	// Work out the frame bytes one accepted request causes.
	function automatic void predict_frame_bytes(logic op, logic [3:0] mask, logic [15:0] val,
		logic ok);
		int          len;
		logic [15:0] v;
		if (op == OP_START) begin
			len = HDR_LEN;
			for (int s = 0; s < NUM_SLOTS_DEF; s++)
				if (cfg_en[s])
					len += 2 + 2 * int'(regs_of(s));
			frame_live = 1'b0;
			cur_slot   = '0;
			cur_reg    = '0;
			crc_run    = CRC_INIT;
			frame_starts++;
			if (len > LEN_LIMIT) begin
				frame_rejects++;
				emit_raw(8'h00, 1'b1, 1'b1);
				return;
			end
			frame_live = 1'b1;
			emit_crc_byte(HDR0);
			emit_crc_byte(HDR1);
			emit_crc_byte(8'(len));
			emit_crc_byte({4'h0, mask});
			next_slots(0);
		end else if (frame_live) begin
			v = ok ? val : 16'h0000;
			emit_crc_byte(v[15:8]);
			emit_crc_byte(v[7:0]);
			cur_reg = cur_reg + 4'd1;
			if (cur_reg == 4'd0 || cur_reg >= regs_of(int'(cur_slot)))
				next_slots(int'(cur_slot) + 1);
		end
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH %s: got %02h, want %02h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Present one request and hold it until the handshake; leave tvalid up so
	// a back-to-back request needs no second assignment in the same step.
	task automatic send_request(input logic op, input logic [3:0] mask, input logic [15:0] val,
		input logic ok);
		int base;
		s_tuser  <= op;
		s_tdata  <= {3'b000, ok, val, mask};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		base = bytes_due.size();
		predict_frame_bytes(op, mask, val, ok);
		if (bytes_due.size() > base)
			requests_used++;
		for (int i = 0; i < n_typed; i++)
			bytes_due[base + i] = typed_due[i];
		n_typed = 0;
	endtask

	// Drop tvalid for a random burst now and then.
	task automatic pause_sender();
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Hold off until every predicted byte has arrived, then let the block
	// finish any request that makes no bytes.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			CFG_ENABLE: cfg_en  = v[7:0];
			CFG_IDS:    cfg_ids = v;
			CFG_COUNTS: cfg_cnt = v[31:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		plan_row_t r;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.wval = v;
		r.chk  = CHK_MODEL;
		plan.push_back(r);
	endfunction

	function automatic void plan_req(logic op, logic [3:0] mask, logic [15:0] val, logic ok,
		row_chk_t chk, logic [7:0] len);
		plan_row_t r;
		r.kind = ROW_REQ;
		r.op   = op;
		r.mask = mask;
		r.val  = val;
		r.ok   = ok;
		r.chk  = chk;
		r.len  = len;
		plan.push_back(r);
	endfunction

	// Receiver: random stall bursts while idling is on, otherwise always ready.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(1, 14) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted output byte with the oldest prediction.
	always @(posedge clk) begin : check_out
		tx_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (bytes_due.size() == 0) begin
				flag_mismatch("byte with nothing pending", m_tdata, 8'h00);
			end else begin
				want = bytes_due.pop_front();
				if (m_tdata !== want.data)
					flag_mismatch("out_byte", m_tdata, want.data);
				if (m_tlast !== want.last)
					flag_mismatch("last", 8'(m_tlast), 8'(want.last));
				if (m_tuser[0] !== want.err)
					flag_mismatch("error", 8'(m_tuser[0]), 8'(want.err));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still pending", cycles,
				bytes_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [7:0]  en;
		logic [63:0] ids;
		logic [31:0] cnt;
		logic [15:0] val;
		int          need;
		int          frames;
		bit          first_phase;
		bit          cfg_ready;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		bursts_on = 1'b1;

		// Directed part. Reset configuration: header plus CRC only.
		plan_req(OP_START, 4'hF, 16'h0000, 1'b1, CHK_HEADER, 8'h06);
		plan_req(OP_VALUE, 4'h0, 16'hFFFF, 1'b1, CHK_MODEL, 8'h00);   // no frame: dropped
		// Slots 0 and 7, counts 1 and 2: length 16.
		plan_cfg(CFG_ENABLE, 64'h81);
		plan_cfg(CFG_IDS, 64'hFF00_0000_0000_0001);
		plan_cfg(CFG_COUNTS, 64'h2000_0001);
		plan_req(OP_START, 4'h0, 16'h0000, 1'b0, CHK_HEADER, 8'h10);
		plan_req(OP_VALUE, 4'hF, 16'hFFFF, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'hABCD, 1'b0, CHK_MODEL, 8'h00);   // failed read sends zero
		plan_req(OP_START, 4'h5, 16'h0000, 1'b1, CHK_HEADER, 8'h10);  // abandon open frame
		plan_req(OP_VALUE, 4'hA, 16'h0000, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h5, 16'h8001, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'h7FFE, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'h5555, 1'b1, CHK_MODEL, 8'h00);   // after CRC: dropped
		// All slots, slot 7 at 12 registers and the rest at 15: length 256, rejected.
		plan_cfg(CFG_ENABLE, 64'hFF);
		plan_cfg(CFG_COUNTS, 64'hCFFF_FFFF);
		plan_req(OP_START, 4'hA, 16'h0000, 1'b1, CHK_ERROR, 8'h00);
		plan_req(OP_VALUE, 4'h3, 16'h1111, 1'b1, CHK_MODEL, 8'h00);   // rejected frame: dropped
		// Enabled slots with zero counts are announced and skipped.
		plan_cfg(CFG_ENABLE, 64'h0F);
		plan_cfg(CFG_IDS, 64'h0000_0000_4433_2211);
		plan_cfg(CFG_COUNTS, 64'h0000_0100);
		plan_req(OP_START, 4'h3, 16'h0000, 1'b1, CHK_HEADER, 8'h10);
		plan_req(OP_VALUE, 4'hC, 16'h1234, 1'b1, CHK_MODEL, 8'h00);
		// Counts change while the frame is open; the length byte keeps its value.
		plan_cfg(CFG_ENABLE, 64'h03);
		plan_cfg(CFG_COUNTS, 64'h0000_0011);
		plan_req(OP_START, 4'h9, 16'h0000, 1'b1, CHK_HEADER, 8'h0E);
		plan_cfg(CFG_COUNTS, 64'h0000_0031);
		plan_req(OP_VALUE, 4'h0, 16'h0001, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'h0100, 1'b1, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'h1000, 1'b0, CHK_MODEL, 8'h00);
		plan_req(OP_VALUE, 4'h0, 16'hFFFE, 1'b1, CHK_MODEL, 8'h00);
		// Unmapped index must leave the configuration alone.
		plan_cfg(CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
		plan_req(OP_START, 4'h6, 16'h0000, 1'b1, CHK_HEADER, 8'h12);
		plan_req(OP_VALUE, 4'h0, 16'hABBA, 1'b1, CHK_MODEL, 8'h00);

		cfg_ready = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!cfg_ready)
					settle();
				cfg_write(plan[i].idx, plan[i].wval);
				cfg_ready = 1'b1;
			end else begin
				if (plan[i].chk == CHK_HEADER) begin
					typed_due[0] = '{8'hA5, 1'b0, 1'b0};
					typed_due[1] = '{8'h5A, 1'b0, 1'b0};
					typed_due[2] = '{plan[i].len, 1'b0, 1'b0};
					typed_due[3] = '{{4'h0, plan[i].mask}, 1'b0, 1'b0};
					n_typed = 4;
				end else if (plan[i].chk == CHK_ERROR) begin
					typed_due[0] = '{8'h00, 1'b1, 1'b1};
					n_typed = 1;
				end
				send_request(plan[i].op, plan[i].mask, plan[i].val, plan[i].ok);
				pause_sender();
				cfg_ready = 1'b0;
			end
		end

		// Random part: phases of one setup each, mostly whole frames with random
		// content, some cut short, some followed by stray values.
		first_phase = 1'b1;
		while (requests_used < ITEM_GOAL) begin
			settle();
			ids = {$urandom(), $urandom()};
			for (int s = 0; s < NUM_SLOTS_DEF; s++)
				cnt[4*s +: 4] = 4'($urandom_range(0, 3));
			en = 8'($urandom());
			if (first_phase) begin
				// Longest frame that still fits: length 254.
				en  = 8'hFF;
				cnt = 32'hBFFF_FFFF;
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						en  = 8'h00;
						ids = '0;
					end
					1: begin
						en  = 8'hFF;
						cnt = 32'hFFFF_FFFF;
						ids = '1;
					end
					2: begin
						for (int s = 0; s < NUM_SLOTS_DEF; s++)
							cnt[4*s +: 4] = 4'($urandom_range(0, 1));
						cnt[4*$urandom_range(0, 7) +: 4] = 4'hF;
					end
					default: ;
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				cfg_write(CFG_SPARE, {$urandom(), $urandom()});
			cfg_write(CFG_ENABLE, {56'h0, en});
			cfg_write(CFG_IDS, ids);
			cfg_write(CFG_COUNTS, {32'h0, cnt});

			bursts_on = (requests_used < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			frames = $urandom_range(1, 3);
			repeat (frames) begin
				send_request(OP_START, 4'($urandom_range(0, 15)), 16'($urandom()),
					1'($urandom()));
				pause_sender();
				need = 0;
				if (frame_live)
					for (int s = 0; s < NUM_SLOTS_DEF; s++)
						if (cfg_en[s])
							need += int'(regs_of(s));
				// Cut the frame short now and then; the next start abandons it.
				if (need > 0 && $urandom_range(0, 7) == 0)
					need = $urandom_range(0, need - 1);
				repeat (need) begin
					if ($urandom_range(0, 7) == 0)
						val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					else
						val = 16'($urandom());
					send_request(OP_VALUE, 4'($urandom_range(0, 15)), val,
						$urandom_range(0, 3) != 0);
					pause_sender();
				end
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 2)) begin
						send_request(OP_VALUE, 4'($urandom_range(0, 15)), 16'($urandom()),
							1'($urandom()));
						pause_sender();
					end
			end
			first_phase = 1'b0;
		end

		bursts_on = 1'b0;
		settle();
		$display("%0d requests made bytes: %0d frame starts, %0d rejected as too long",
			requests_used, frame_starts, frame_rejects);
		$display("%0d output bytes compared, %0d failed", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
rtl/sfb_pkg.sv
rtl/sfb_crc16.sv
rtl/sfb_seq.sv
rtl/sensor_frame_builder_crc16.sv
tb/tb.sv
